### hw/rtl/lkvs_pkg.sv
package lkvs_pkg;

  localparam int LKVS_ENTRIES    = 16;
  localparam int LKVS_KEY_BITS   = 64;
  localparam int LKVS_VALUE_BITS = 64;

  localparam int FIELD_BITS     = 64;
  localparam int COUNT_BITS     = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_LOOKUP   = 3'd1;
  localparam logic [2:0] ACT_REMOVE   = 3'd2;
  localparam logic [2:0] ACT_CLEAR    = 3'd3;
  localparam logic [2:0] ACT_CONTAINS = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LRU_ENABLE     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY_LIMIT = 2'd1;

  typedef struct packed {
    logic [2:0]            action;
    logic [FIELD_BITS-1:0] entry_key;
    logic [FIELD_BITS-1:0] entry_value;
    logic                  value_empty;
  } lkvs_cmd_t;

  typedef struct packed {
    logic                  found;
    logic [FIELD_BITS-1:0] read_value;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] evicted_count;
    logic [COUNT_BITS-1:0] occupancy;
  } lkvs_result_t;

endpackage

### hw/rtl/lkvs_ram.sv
module lkvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/lru_key_value_store.sv
// Fully associative key/value store kept in least-recently-used order.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// busy stays high until the command has finished; the result beat is shown
// on result for exactly one cycle, marked by done, and cannot be held off.
// Configuration channel: cfg_index/cfg_data are written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high. Index 0 is lru_enable,
// index 1 is capacity_limit; other indexes are ignored. Write it while idle.
// Each command first sweeps the key and rank memories, one entry a cycle.
// Promotion, removal and insertion of a new key then need a second sweep
// that rewrites the ranks. The states run SEARCH, DECIDE, UPDATE (only when
// the ranks are rewritten) and FINISH, which registers done. The next
// command may be given in the cycle of done.
// The rate is set by the single read port of the memories, walked one
// entry per cycle.
// Synchronous reset empties the table, sets lru_enable to 1 and
// capacity_limit to 0; the memories are not cleared, valid bits guard them.
module lru_key_value_store import lkvs_pkg::*; #(
  parameter int ENTRIES    = LKVS_ENTRIES,
  parameter int KEY_BITS   = LKVS_KEY_BITS,
  parameter int VALUE_BITS = LKVS_VALUE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  lkvs_cmd_t                 cmd,
  output logic                      done,
  output lkvs_result_t              result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int RW   = IW;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int EW   = KEY_BITS + VALUE_BITS;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;
  localparam logic [1:0] S_FINISH = 2'd3 ^ 2'd3;

  localparam logic [1:0] M_NONE    = 2'd0;
  localparam logic [1:0] M_PROMOTE = 2'd1;
  localparam logic [1:0] M_DROP    = 2'd2;
  localparam logic [1:0] M_AGE     = 2'd3;

  logic [2:0]            state;
  logic [1:0]            mode;
  logic [1:0]            decide_mode;
  logic                  lru_enable;
  logic [COUNT_BITS-1:0] capacity_limit;
  logic [ENTRIES-1:0]    valid;
  logic [CW-1:0]         count;
  lkvs_cmd_t             cmd_q;

  logic                  issue_on;
  logic [IW-1:0]         issue_idx;
  logic                  chk_on;
  logic [IW-1:0]         chk_idx;

  logic                  hit;
  logic [IW-1:0]         hit_idx;
  logic [RW-1:0]         hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  evict_on;
  logic [CMPW-1:0]       thresh;
  logic                  free_found;
  logic [IW-1:0]         free_idx;

  logic                  found_q;
  logic [FIELD_BITS-1:0] rval_q;
  logic [1:0]            status_q;
  logic [COUNT_BITS-1:0] evicted_q;

  logic                  ent_we;
  logic [IW-1:0]         ent_waddr;
  logic [EW-1:0]         ent_wdata;
  logic [EW-1:0]         ent_rdata;
  logic                  rank_we;
  logic [IW-1:0]         rank_waddr;
  logic [RW-1:0]         rank_wdata;
  logic [RW-1:0]         rank_rdata;

  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [CMPW-1:0]       count_x;
  logic [CMPW-1:0]       limit_x;
  logic [CMPW-1:0]       rank_x;
  logic [CMPW-1:0]       count_kept;
  logic                  over_limit;
  logic                  table_full;
  logic                  drop_now;
  logic                  free_now;

  // The FSM uses a 3-bit vector so that FINISH gets a code of its own.
  localparam logic [2:0] ST_IDLE   = {1'b0, S_IDLE};
  localparam logic [2:0] ST_SEARCH = {1'b0, S_SEARCH};
  localparam logic [2:0] ST_DECIDE = {1'b0, S_DECIDE};
  localparam logic [2:0] ST_UPDATE = {1'b0, S_UPDATE};
  localparam logic [2:0] ST_FINISH = {1'b1, S_FINISH};

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign key_in   = cmd_q.entry_key[KEY_BITS-1:0];
  assign val_in   = cmd_q.entry_value[VALUE_BITS-1:0];
  assign rd_key   = ent_rdata[EW-1:VALUE_BITS];
  assign rd_value = ent_rdata[VALUE_BITS-1:0];

  // Ranks of valid entries always form 0..count-1, so eviction simply drops
  // every entry whose rank is at or above limit-1, with no renumbering.
  assign count_x    = CMPW'(count);
  assign limit_x    = CMPW'(capacity_limit);
  assign rank_x     = CMPW'(rank_rdata);
  assign over_limit = lru_enable && (capacity_limit != '0) && (count_x >= limit_x);
  assign count_kept = over_limit ? (limit_x - 1'b1) : count_x;
  assign table_full = (count_kept >= CMPW'(ENTRIES));

  lkvs_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (ent_waddr),
    .wr_data (ent_wdata),
    .rd_en   (issue_on),
    .rd_addr (issue_idx),
    .rd_data (ent_rdata)
  );

  lkvs_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_rank_ram (
    .clk     (clk),
    .wr_en   (rank_we),
    .wr_addr (rank_waddr),
    .wr_data (rank_wdata),
    .rd_en   (issue_on),
    .rd_addr (issue_idx),
    .rd_data (rank_rdata)
  );

  always_comb begin
    decide_mode = M_NONE;
    case (cmd_q.action)
      ACT_INSERT: begin
        if (!cmd_q.value_empty) begin
          if (hit) begin
            decide_mode = lru_enable ? M_PROMOTE : M_NONE;
          end else if (!table_full) begin
            decide_mode = M_AGE;
          end
        end
      end
      ACT_LOOKUP: begin
        if (hit && lru_enable) begin
          decide_mode = M_PROMOTE;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          decide_mode = M_DROP;
        end
      end
      default: begin
        decide_mode = M_NONE;
      end
    endcase
  end

  // Rank rewrite: the sweep writes entry i while it reads entry i+1, so the
  // two ports never meet on one address.
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = chk_idx;
    rank_wdata = rank_rdata;
    drop_now   = 1'b0;
    free_now   = 1'b0;
    if (state == ST_UPDATE && chk_on) begin
      case (mode)
        M_PROMOTE: begin
          if (valid[chk_idx]) begin
            rank_we = 1'b1;
            if (chk_idx == hit_idx) begin
              rank_wdata = '0;
            end else if (rank_rdata < hit_rank) begin
              rank_wdata = rank_rdata + 1'b1;
            end
          end
        end
        M_DROP: begin
          if (chk_idx == hit_idx) begin
            drop_now = 1'b1;
          end else if (valid[chk_idx] && rank_rdata > hit_rank) begin
            rank_we    = 1'b1;
            rank_wdata = rank_rdata - 1'b1;
          end
        end
        M_AGE: begin
          if (!valid[chk_idx]) begin
            free_now = 1'b1;
          end else if (evict_on && rank_x >= thresh) begin
            drop_now = 1'b1;
            free_now = 1'b1;
          end else begin
            rank_we    = 1'b1;
            rank_wdata = rank_rdata + 1'b1;
          end
        end
        default: begin
          rank_we = 1'b0;
        end
      endcase
    end else if (state == ST_FINISH && mode == M_AGE) begin
      rank_we    = 1'b1;
      rank_waddr = free_idx;
      rank_wdata = '0;
    end
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = hit_idx;
    ent_wdata = {key_in, val_in};
    if (state == ST_DECIDE && cmd_q.action == ACT_INSERT && !cmd_q.value_empty && hit) begin
      ent_we = 1'b1;
    end else if (state == ST_FINISH && mode == M_AGE) begin
      ent_we    = 1'b1;
      ent_waddr = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= M_NONE;
      lru_enable     <= 1'b1;
      capacity_limit <= '0;
      valid          <= '0;
      count          <= '0;
      issue_on       <= 1'b0;
      issue_idx      <= '0;
      chk_on         <= 1'b0;
      chk_idx        <= '0;
      done           <= 1'b0;
    end else begin
      done    <= 1'b0;
      chk_on  <= issue_on;
      chk_idx <= issue_idx;

      if (issue_on) begin
        if (issue_idx == LAST) begin
          issue_on <= 1'b0;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LRU_ENABLE:     lru_enable     <= cfg_data[0];
          CFG_CAPACITY_LIMIT: capacity_limit <= cfg_data[COUNT_BITS-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q     <= cmd;
            hit       <= 1'b0;
            issue_on  <= 1'b1;
            issue_idx <= '0;
            state     <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (chk_on) begin
            if (valid[chk_idx] && rd_key == key_in && !hit) begin
              hit       <= 1'b1;
              hit_idx   <= chk_idx;
              hit_rank  <= rank_rdata;
              hit_value <= rd_value;
            end
            if (chk_idx == LAST) begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          found_q    <= 1'b0;
          rval_q     <= '0;
          status_q   <= ST_DONE;
          evicted_q  <= '0;
          evict_on   <= 1'b0;
          free_found <= 1'b0;
          thresh     <= limit_x - 1'b1;
          mode       <= decide_mode;
          case (cmd_q.action)
            ACT_INSERT: begin
              if (cmd_q.value_empty) begin
                status_q <= ST_EMPTY;
              end else if (hit) begin
                found_q <= 1'b1;
              end else if (table_full) begin
                status_q <= ST_FULL;
              end else begin
                evict_on  <= over_limit;
                evicted_q <= COUNT_BITS'(count_x - count_kept);
                count     <= CW'(count_kept + 1'b1);
              end
            end
            ACT_LOOKUP: begin
              if (hit) begin
                found_q <= 1'b1;
                rval_q  <= FIELD_BITS'(hit_value);
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                found_q <= 1'b1;
                count   <= count - 1'b1;
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end
            ACT_CLEAR: begin
              valid <= '0;
              count <= '0;
            end
            ACT_CONTAINS: begin
              if (hit) begin
                found_q <= 1'b1;
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
          if (decide_mode == M_NONE) begin
            state <= ST_FINISH;
          end else begin
            issue_on  <= 1'b1;
            issue_idx <= '0;
            state     <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (chk_on) begin
            if (drop_now) begin
              valid[chk_idx] <= 1'b0;
            end
            if (free_now && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (chk_idx == LAST) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (mode == M_AGE) begin
            valid[free_idx] <= 1'b1;
          end
          done                 <= 1'b1;
          result.found         <= found_q;
          result.read_value    <= rval_q;
          result.status        <= status_q;
          result.evicted_count <= evicted_q;
          result.occupancy     <= COUNT_BITS'(count);
          state                <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (count == CW'($countones(valid))))
    else $error("entry count differs from the number of valid entries");

  a_free_slot_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && mode == M_AGE) |-> free_found)
    else $error("new entry written without a free slot");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_FINISH))
    else $error("result beat without a finished command");
`endif

endmodule

### verif/lru_key_value_store_tb.sv
`timescale 1ns / 1ps

module lru_key_value_store_tb;
  import lkvs_pkg::*;

  localparam int SLOTS = LKVS_ENTRIES;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * LKVS_ENTRIES + 8;
  localparam int RANDOM_PER_PHASE = 219;
  localparam int KEY_POOL_SIZE = 20;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lkvs_cmd_t cmd = '0;
  logic done;
  lkvs_result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  lru_key_value_store u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the table, kept in step with every accepted command.
  logic [LKVS_KEY_BITS-1:0] shadow_key[SLOTS];
  logic [LKVS_VALUE_BITS-1:0] shadow_val[SLOTS];
  bit shadow_valid[SLOTS];
  int shadow_rank[SLOTS];
  int shadow_count = 0;
  bit shadow_lru_en = 1'b1;
  int shadow_limit = 0;

  lkvs_result_t awaited_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  logic [63:0] key_pool[KEY_POOL_SIZE];

  typedef struct {
    bit is_mode;
    bit lru;
    int limit;
    lkvs_cmd_t c;
    int reps;
    bit typed;
    lkvs_result_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic int find_slot(logic [LKVS_KEY_BITS-1:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void make_most_recent(int e);
    int r;
    r = shadow_rank[e];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && i != e && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[e] = 0;
  endfunction

  function automatic void drop_slot(int e);
    int r;
    r = shadow_rank[e];
    shadow_valid[e] = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
    if (shadow_count > 0) shadow_count--;
  endfunction

  function automatic lkvs_result_t next_store_result(lkvs_cmd_t c);
    lkvs_result_t r;
    int e;
    int oldest;
    int evicted;
    r = '0;
    evicted = 0;
    case (c.action)
      ACT_INSERT: begin
        if (c.value_empty) begin
          r.status = ST_EMPTY;
        end else begin
          e = find_slot(c.entry_key);
          if (e >= 0) begin
            shadow_val[e] = c.entry_value;
            if (shadow_lru_en) make_most_recent(e);
            r.found = 1'b1;
          end else begin
            if (shadow_lru_en && shadow_limit != 0) begin
              while (shadow_count >= shadow_limit) begin
                oldest = -1;
                for (int i = 0; i < SLOTS; i++)
                  if (shadow_valid[i] && (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
                    oldest = i;
                if (oldest < 0) break;
                drop_slot(oldest);
                evicted++;
              end
            end
            e = -1;
            for (int i = 0; i < SLOTS; i++)
              if (!shadow_valid[i] && e < 0) e = i;
            if (e < 0) begin
              r.status = ST_FULL;
            end else begin
              // The new key always enters as the most recent entry.
              for (int i = 0; i < SLOTS; i++)
                if (shadow_valid[i]) shadow_rank[i]++;
              shadow_key[e] = c.entry_key;
              shadow_val[e] = c.entry_value;
              shadow_rank[e] = 0;
              shadow_valid[e] = 1'b1;
              shadow_count++;
            end
          end
        end
      end
      ACT_LOOKUP: begin
        e = find_slot(c.entry_key);
        if (e >= 0) begin
          if (shadow_lru_en) make_most_recent(e);
          r.found = 1'b1;
          r.read_value = shadow_val[e];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        e = find_slot(c.entry_key);
        if (e >= 0) begin
          drop_slot(e);
          r.found = 1'b1;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
        shadow_count = 0;
      end
      ACT_CONTAINS: begin
        if (find_slot(c.entry_key) >= 0) r.found = 1'b1;
        else r.status = ST_NOT_FOUND;
      end
      default: begin
      end
    endcase
    r.evicted_count = COUNT_BITS'(evicted);
    r.occupancy = COUNT_BITS'(shadow_count);
    return r;
  endfunction

  function automatic lkvs_result_t outcome(logic f, logic [63:0] v, logic [1:0] s, int ev,
                                           int occ);
    lkvs_result_t r;
    r.found = f;
    r.read_value = v;
    r.status = s;
    r.evicted_count = COUNT_BITS'(ev);
    r.occupancy = COUNT_BITS'(occ);
    return r;
  endfunction

  function automatic void add_cmd(logic [2:0] act, logic [63:0] k, logic [63:0] v, bit e,
                                  int reps, bit typed, lkvs_result_t want);
    plan_row_t row;
    row.is_mode = 1'b0;
    row.lru = 1'b0;
    row.limit = 0;
    row.c.action = act;
    row.c.entry_key = k;
    row.c.entry_value = v;
    row.c.value_empty = e;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endfunction

  function automatic void add_mode(bit lru, int limit);
    plan_row_t row;
    row.is_mode = 1'b1;
    row.lru = lru;
    row.limit = limit;
    row.c = '0;
    row.reps = 0;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  function automatic lkvs_cmd_t random_cmd();
    lkvs_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 36) c.action = ACT_INSERT;
    else if (roll < 61) c.action = ACT_LOOKUP;
    else if (roll < 74) c.action = ACT_REMOVE;
    else if (roll < 88) c.action = ACT_CONTAINS;
    else if (roll < 91) c.action = ACT_CLEAR;
    else c.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    // Mostly keys from a small pool, so that hits, evictions and a full table occur.
    if ($urandom_range(0, 99) < 85) c.entry_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    else c.entry_key = {$urandom, $urandom};
    c.entry_value = {$urandom, $urandom};
    c.value_empty = ($urandom_range(0, 9) == 0);
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // start is left high when the task returns; the next call sets it again or drops it for an idle gap.
  task automatic send_cmd(input lkvs_cmd_t c, input bit typed, input lkvs_result_t want);
    lkvs_result_t predicted;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_store_result(c);
    awaited_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Both registers in back-to-back beats; valid stays high between them.
  task automatic set_mode(input bit lru, input int limit);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LRU_ENABLE;
    cfg_data <= CFG_DATA_BITS'(lru);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_lru_en = lru;
    @(negedge clk);
    cfg_index <= CFG_CAPACITY_LIMIT;
    cfg_data <= CFG_DATA_BITS'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_limit = limit;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    lkvs_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = awaited_results.pop_front();
        if (result.found !== want.found || result.read_value !== want.read_value ||
            result.status !== want.status || result.evicted_count !== want.evicted_count ||
            result.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("result %0d (expected/actual): found %b/%b value %h/%h", results_seen,
                   want.found, result.found, want.read_value, result.read_value);
            $display(" status %0d/%0d evicted %0d/%0d occupancy %0d/%0d",
                     want.status, result.status, want.evicted_count, result.evicted_count,
                     want.occupancy, result.occupancy);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    lkvs_cmd_t c;
    bit phase_lru[8];
    int phase_limit[8];
    phase_lru = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    phase_limit = '{0, 16, 1, 8, 5, 0, 12, 3};
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};

    // Directed part: reset state, extremes of key and value, every action.
    add_cmd(ACT_LOOKUP, '0, '0, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_NOT_FOUND, 0, 0));
    add_cmd(ACT_CONTAINS, '1, '0, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_NOT_FOUND, 0, 0));
    add_cmd(ACT_REMOVE, '0, '1, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_NOT_FOUND, 0, 0));
    add_cmd(ACT_INSERT, 64'h1234, '1, 1'b1, 1, 1'b1, outcome(1'b0, '0, ST_EMPTY, 0, 0));
    add_cmd(ACT_INSERT, '0, '1, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 1));
    add_cmd(ACT_INSERT, '1, '0, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 2));
    add_cmd(ACT_LOOKUP, '0, '0, 1'b0, 1, 1'b1, outcome(1'b1, '1, ST_DONE, 0, 2));
    add_cmd(ACT_LOOKUP, '1, '1, 1'b0, 1, 1'b1, outcome(1'b1, '0, ST_DONE, 0, 2));
    add_cmd(ACT_INSERT, '0, 64'h5a5a_a5a5_0f0f_f0f0, 1'b0, 1, 1'b1,
            outcome(1'b1, '0, ST_DONE, 0, 2));
    add_cmd(ACT_CONTAINS, '0, '0, 1'b0, 1, 1'b1, outcome(1'b1, '0, ST_DONE, 0, 2));
    add_cmd(ACT_UNUSED_LO, '0, '1, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 2));
    add_cmd(ACT_UNUSED_HI, '1, '1, 1'b1, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 2));
    add_cmd(ACT_REMOVE, '1, '0, 1'b0, 1, 1'b1, outcome(1'b1, '0, ST_DONE, 0, 1));
    add_cmd(ACT_CLEAR, '0, '0, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 0));
    // Fill the whole table with no limit, then one more new key is dropped.
    add_cmd(ACT_INSERT, 64'h100, 64'hcafe_0000, 1'b0, SLOTS, 1'b0, '0);
    add_cmd(ACT_INSERT, 64'hdead, 64'h1, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_FULL, 0, 16));
    add_cmd(ACT_LOOKUP, 64'h100, '0, 1'b0, 1, 1'b0, '0);
    // At the table size as the limit one entry goes, the oldest one that was not promoted.
    add_mode(1'b1, 16);
    add_cmd(ACT_INSERT, 64'hbeef, 64'h2, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 1, 16));
    add_cmd(ACT_CONTAINS, 64'h101, '0, 1'b0, 1, 1'b1,
            outcome(1'b0, '0, ST_NOT_FOUND, 0, 16));
    add_mode(1'b1, 3);
    add_cmd(ACT_INSERT, 64'hc0de, 64'h3, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 14, 3));
    // With recency off a new key enters without eviction, and hits do not promote.
    add_mode(1'b0, 3);
    add_cmd(ACT_INSERT, 64'hf00d, 64'h4, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 4));
    add_cmd(ACT_LOOKUP, 64'hc0de, '0, 1'b0, 1, 1'b0, '0);
    add_cmd(ACT_INSERT, 64'hc0de, 64'h5, 1'b0, 1, 1'b0, '0);
    add_cmd(ACT_CLEAR, '1, '1, 1'b0, 1, 1'b1, outcome(1'b0, '0, ST_DONE, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_pct = 33;
    foreach (plan[i]) begin
      if (plan[i].is_mode) begin
        wait_until_drained();
        set_mode(plan[i].lru, plan[i].limit);
      end else begin
        for (int r = 0; r < plan[i].reps; r++) begin
          c = plan[i].c;
          c.entry_key = plan[i].c.entry_key + 64'(r);
          send_cmd(c, plan[i].typed, plan[i].want);
        end
      end
    end

    for (int p = 0; p < 8; p++) begin
      idle_pct = (p < 3) ? 33 : (p < 6) ? 81 : 0;
      wait_until_drained();
      set_mode(phase_lru[p], phase_limit[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_cmd(random_cmd(), 1'b0, '0);
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lkvs_pkg.sv
hw/rtl/lkvs_ram.sv
hw/rtl/lru_key_value_store.sv
verif/lru_key_value_store_tb.sv
